// File: rtl/core/tabp_pkg.sv
package tabp_pkg;

  localparam int unsigned NumSlots = 5;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  localparam logic [4:0] TERRAIN_OFFSET = 5'd4;

  // combination codes
  localparam logic [5:0] CODE_MULTI_FLOOR   = 6'h29;
  localparam logic [5:0] CODE_SPLIT_H       = 6'h2A;
  localparam logic [5:0] CODE_SPLIT_V       = 6'h2B;
  localparam logic [5:0] CODE_SPLIT_H_LOW   = 6'h2C;
  localparam logic [5:0] CODE_SPLIT_V_RIGHT = 6'h2D;
  localparam logic [5:0] CODE_QUAD          = 6'h2E;
  localparam logic [5:0] CODE_ISLAND        = 6'h31;

  typedef struct packed {
    logic [3:0] terrain;
    logic [5:0] combination;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
  } req_t;

  typedef struct packed {
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic [4:0]  width;
    logic [4:0]  height;
    logic        last;
  } cmd_t;

  // one piece: offsets into the terrain block, half-tile destination shifts, size
  typedef struct packed {
    logic       en;
    logic [5:0] sx;
    logic [5:0] sy;
    logic       ox8;
    logic       oy8;
    logic       wide;
    logic       tall;
  } piece_t;

  typedef piece_t [NumSlots-1:0] plan_t;

  function automatic piece_t mk(input logic [5:0] sx, input logic [5:0] sy,
                                input logic ox8, input logic oy8,
                                input logic wide, input logic tall);
    piece_t p;
    p.en   = 1'b1;
    p.sx   = sx;
    p.sy   = sy;
    p.ox8  = ox8;
    p.oy8  = oy8;
    p.wide = wide;
    p.tall = tall;
    return p;
  endfunction

  function automatic plan_t plan_of(input logic [5:0] c);
    plan_t p;
    logic  b0;
    logic  b1;
    p  = '0;
    b0 = c[0];
    b1 = c[1];
    p[0] = mk(6'd16, 6'd32, 1'b0, 1'b0, 1'b1, 1'b1);
    if (c[5]) begin
      if (c > CODE_MULTI_FLOOR) begin
        case (c)
          CODE_SPLIT_H: begin
            p[1] = mk(6'd0,  6'd16, 1'b0, 1'b0, 1'b0, 1'b1);
            p[2] = mk(6'd40, 6'd16, 1'b1, 1'b0, 1'b0, 1'b1);
          end
          CODE_SPLIT_V: begin
            p[1] = mk(6'd0, 6'd16, 1'b0, 1'b0, 1'b1, 1'b0);
            p[2] = mk(6'd0, 6'd56, 1'b0, 1'b1, 1'b1, 1'b0);
          end
          CODE_SPLIT_H_LOW: begin
            p[1] = mk(6'd0,  6'd48, 1'b0, 1'b0, 1'b0, 1'b1);
            p[2] = mk(6'd40, 6'd48, 1'b1, 1'b0, 1'b0, 1'b1);
          end
          CODE_SPLIT_V_RIGHT: begin
            p[1] = mk(6'd32, 6'd16, 1'b0, 1'b0, 1'b1, 1'b0);
            p[2] = mk(6'd32, 6'd56, 1'b0, 1'b1, 1'b1, 1'b0);
          end
          CODE_QUAD: begin
            p[1] = mk(6'd0,  6'd16, 1'b0, 1'b0, 1'b0, 1'b0);
            p[2] = mk(6'd40, 6'd16, 1'b1, 1'b0, 1'b0, 1'b0);
            p[3] = mk(6'd0,  6'd56, 1'b0, 1'b1, 1'b0, 1'b0);
            p[4] = mk(6'd40, 6'd56, 1'b1, 1'b1, 1'b0, 1'b0);
          end
          CODE_ISLAND: begin
            p[1] = mk(6'd0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1);
          end
          default: begin
          end
        endcase
      end else begin
        case (c[3:1])
          3'd0: begin
            if (b0) begin
              p[1] = mk(6'd16, 6'd16, 1'b0, 1'b0, 1'b1, 1'b0);
              p[2] = mk(6'd16, 6'd56, 1'b0, 1'b1, 1'b1, 1'b0);
            end else begin
              p[1] = mk(6'd0,  6'd32, 1'b0, 1'b0, 1'b0, 1'b1);
              p[2] = mk(6'd40, 6'd32, 1'b1, 1'b0, 1'b0, 1'b1);
            end
          end
          3'd1: begin
            p[1] = mk(6'd0,  6'd16, 1'b0, 1'b0, 1'b1, 1'b1);
            p[2] = mk(6'd40, 6'd8,  1'b1, 1'b1, 1'b0, 1'b0);
            p[2].en = b0;
          end
          3'd2: begin
            p[1] = mk(6'd32, 6'd16, 1'b0, 1'b0, 1'b1, 1'b1);
            p[2] = mk(6'd32, 6'd8,  1'b0, 1'b1, 1'b0, 1'b0);
            p[2].en = b0;
          end
          3'd3: begin
            p[1] = mk(6'd32, 6'd48, 1'b0, 1'b0, 1'b1, 1'b1);
            p[2] = mk(6'd32, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
            p[2].en = b0;
          end
          3'd4: begin
            p[1] = mk(6'd0,  6'd48, 1'b0, 1'b0, 1'b1, 1'b1);
            p[2] = mk(6'd40, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
            p[2].en = b0;
          end
          default: begin
          end
        endcase
      end
    end else if (c[4]) begin
      case (c[3:2])
        2'd0: begin
          p[1] = mk(6'd0,  6'd32, 1'b0, 1'b0, 1'b1, 1'b1);
          p[2] = mk(6'd40, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
          p[3] = mk(6'd40, 6'd8,  1'b1, 1'b1, 1'b0, 1'b0);
        end
        2'd1: begin
          p[1] = mk(6'd16, 6'd16, 1'b0, 1'b0, 1'b1, 1'b1);
          p[2] = mk(6'd40, 6'd8,  1'b1, 1'b1, 1'b0, 1'b0);
          p[3] = mk(6'd32, 6'd8,  1'b0, 1'b1, 1'b0, 1'b0);
        end
        2'd2: begin
          p[1] = mk(6'd32, 6'd32, 1'b0, 1'b0, 1'b1, 1'b1);
          p[2] = mk(6'd32, 6'd8,  1'b0, 1'b1, 1'b0, 1'b0);
          p[3] = mk(6'd32, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          p[1] = mk(6'd16, 6'd48, 1'b0, 1'b0, 1'b1, 1'b1);
          p[2] = mk(6'd32, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0);
          p[3] = mk(6'd40, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0);
        end
      endcase
      p[2].en = b0;
      p[3].en = b1;
    end else begin
      p[1] = mk(6'd32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      p[2] = mk(6'd40, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      p[3] = mk(6'd40, 6'd8, 1'b1, 1'b1, 1'b0, 1'b0);
      p[4] = mk(6'd32, 6'd8, 1'b0, 1'b1, 1'b0, 1'b0);
      p[1].en = b0;
      p[2].en = b1;
      p[3].en = c[2];
      p[4].en = c[3];
    end
    return p;
  endfunction

endpackage

// File: rtl/core/terrain_autotile_blit_planner.sv
// channel | valid     | stall     | payload         | moves
// request | req_valid | req_stall | req (req_t)     | one tile: terrain, code, position
// command | cmd_valid | cmd_stall | cmd (cmd_t)     | one rectangle copy, last on final
//
// One request yields one to five commands, one per cycle while cmd_stall is low,
// all passing through the single command register.
// The next request is taken in the cycle its predecessor's final command is loaded.
// Synchronous active-high reset clears the valid flags and the slot index.
// A stalled command holds in its register; the pending request waits behind it.
module terrain_autotile_blit_planner (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  tabp_pkg::req_t   req,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output tabp_pkg::cmd_t   cmd
);
  import tabp_pkg::*;

  logic             pend_valid;
  req_t             pend;
  logic [SlotW-1:0] slot;

  plan_t            plan;
  piece_t           cur;
  logic [SlotW-1:0] slot_next;
  logic             found;
  logic             is_last;
  logic [4:0]       t;
  logic [7:0]       bx;
  logic [7:0]       by;
  cmd_t             cmd_next;
  logic             load;
  logic             req_take;

  always_comb begin
    plan      = plan_of(pend.combination);
    cur       = plan[slot];
    slot_next = slot;
    found     = 1'b0;
    for (int i = NumSlots - 1; i > 0; i--) begin
      if (plan[i].en && (SlotW'(i) > slot)) begin
        slot_next = SlotW'(i);
        found     = 1'b1;
      end
    end
    is_last = !found;
  end

  always_comb begin
    t  = {1'b0, pend.terrain} + TERRAIN_OFFSET;
    bx = 8'((t[0] ? 9'd48 : 9'd0) + 9'(t[4:3]) * 9'd96);
    by = {t[2:1], 6'd0};
    cmd_next.src_x  = bx + {2'b00, cur.sx};
    cmd_next.src_y  = by + {2'b00, cur.sy};
    cmd_next.out_x  = {1'b0, pend.dest_x} + (cur.ox8 ? 11'd8 : 11'd0);
    cmd_next.out_y  = {1'b0, pend.dest_y} + (cur.oy8 ? 11'd8 : 11'd0);
    cmd_next.width  = cur.wide ? 5'd16 : 5'd8;
    cmd_next.height = cur.tall ? 5'd16 : 5'd8;
    cmd_next.last   = is_last;
  end

  assign load      = pend_valid && (!cmd_valid || !cmd_stall);
  assign req_stall = pend_valid && !(load && is_last);
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      slot       <= '0;
    end else if (req_take) begin
      pend_valid <= 1'b1;
      slot       <= '0;
    end else if (load && is_last) begin
      pend_valid <= 1'b0;
    end else if (load) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      pend <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (load) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_next;
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    req_take |=> pend_valid && (slot == '0))
    else $error("request taken but not pending at slot zero");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && !cmd.last |=> cmd_valid)
    else $error("command stream broke before last");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (slot < SlotW'(NumSlots)))
    else $error("slot index beyond plan");

  a_idle_open: assert property (@(posedge clk) disable iff (rst)
    !pend_valid |-> !req_stall)
    else $error("stall raised with nothing pending");

endmodule
